// ===== src/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned DUR_W  = 16;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_PAUSE = 3'd5;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD  = 2'd0,
      STATUS_DOOR  = 2'd1,
      STATUS_WARM  = 2'd2,
      STATUS_FAULT = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SLOW_HALF = 2'd0,
      REG_FAST_HALF = 2'd1,
      REG_FLASH     = 2'd2,
      REG_PAUSE     = 2'd3
   } reg_index_type;

   localparam logic [DUR_W-1:0] SLOW_HALF_RESET = 16'd1000;
   localparam logic [DUR_W-1:0] FAST_HALF_RESET = 16'd200;
   localparam logic [DUR_W-1:0] FLASH_RESET     = 16'd150;
   localparam logic [DUR_W-1:0] PAUSE_RESET     = 16'd1000;

   typedef struct packed {
      logic [DUR_W-1:0] slow_half_ms;
      logic [DUR_W-1:0] fast_half_ms;
      logic [DUR_W-1:0] flash_ms;
      logic [DUR_W-1:0] pause_ms;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] now_ms;
      status_type        new_status;
   } item_type;

   typedef struct packed {
      logic       led_lit;
      status_type shown_status;
   } result_type;

endpackage

// ===== src/slpg_csr.sv =====
// ----------------------------------------------------------------------------
// slpg_csr
// Configuration registers holding the blink and flash timings.
// ----------------------------------------------------------------------------
module slpg_csr
   import slpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [DUR_W-1:0]       wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index_type'(wr_index))
            REG_SLOW_HALF: cfg_in.slow_half_ms = wr_data;
            REG_FAST_HALF: cfg_in.fast_half_ms = wr_data;
            REG_FLASH:     cfg_in.flash_ms     = wr_data;
            REG_PAUSE:     cfg_in.pause_ms     = wr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_half_ms <= SLOW_HALF_RESET;
         cfg_ff.fast_half_ms <= FAST_HALF_RESET;
         cfg_ff.flash_ms     <= FLASH_RESET;
         cfg_ff.pause_ms     <= PAUSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/slpg_core.sv =====
// ----------------------------------------------------------------------------
// slpg_core
// Pattern state and its update for one item: status changes, blink toggling
// and the six-phase error flash sequence.
// ----------------------------------------------------------------------------
module slpg_core
   import slpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   status_type         mode_ff, mode_in;
   logic               led_ff, led_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic               started_ff, started_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   logic [TIME_W-1:0]  elapsed;
   logic [DUR_W-1:0]   duration;
   logic               expired;
   logic [PHASE_W-1:0] phase_step;

   always_comb begin
      case (mode_ff)
         STATUS_DOOR: duration = cfg.slow_half_ms;
         STATUS_WARM: duration = cfg.fast_half_ms;
         default:     duration = (phase_ff >= PHASE_PAUSE) ? cfg.pause_ms : cfg.flash_ms;
      endcase
   end

   assign elapsed    = item.now_ms - last_ff;
   assign expired    = elapsed >= {{(TIME_W-DUR_W){1'b0}}, duration};
   assign phase_step = (phase_ff >= PHASE_PAUSE) ? PHASE_FIRST : phase_ff + 3'd1;

   always_comb begin
      mode_in    = mode_ff;
      led_in     = led_ff;
      last_in    = last_ff;
      started_in = started_ff;
      phase_in   = phase_ff;
      if (item.kind == KIND_SET) begin
         if (item.new_status != mode_ff) begin
            mode_in    = item.new_status;
            phase_in   = PHASE_FIRST;
            started_in = 1'b0;
         end
      end else if (mode_ff == STATUS_GOOD) begin
         led_in = 1'b1;
      end else if (!started_ff) begin
         started_in = 1'b1;
         last_in    = item.now_ms;
         led_in     = 1'b1;
         if (mode_ff == STATUS_FAULT) begin
            phase_in = PHASE_FIRST;
         end
      end else if (expired) begin
         last_in = item.now_ms;
         if (mode_ff == STATUS_FAULT) begin
            phase_in = phase_step;
            led_in   = ~phase_step[0];
         end else begin
            led_in = ~led_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= STATUS_GOOD;
         led_ff     <= 1'b1;
         last_ff    <= '0;
         started_ff <= 1'b0;
         phase_ff   <= PHASE_FIRST;
      end else if (enable) begin
         mode_ff    <= mode_in;
         led_ff     <= led_in;
         last_ff    <= last_in;
         started_ff <= started_in;
         phase_ff   <= phase_in;
      end
   end

   assign result.led_lit      = led_in;
   assign result.shown_status = mode_in;

endmodule

// ===== src/status_led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Drives one status LED from a status-selected blink or flash pattern.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel: a tick carrying the millisecond time or
// a status change. Each item gives exactly one transfer on the rsp_ channel
// with the LED drive and the status shown after that item.
// An item passes through an input register and then the result register, from
// which the result is offered. One item is taken every cycle while req_stall
// is low; the pattern state update between the two registers sets that rate.
// When rsp_stall is held the result register keeps its value and, once the
// input register is also occupied, req_stall is raised; nothing is dropped.
// Timings are written over the csr_ channel, which is always ready.
// Reset restores the default timings, shows status OK with the LED on and
// empties both registers.
// ----------------------------------------------------------------------------
module status_led_pattern_generator
   import slpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic [1:0]             req_new_status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_led_lit,
   output logic [1:0]             rsp_shown_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]       csr_data
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   logic       out_valid_ff;
   result_type result;
   result_type result_ff;
   logic       out_free;
   logic       advance;
   logic       in_free;

   assign csr_ready = 1'b1;

   slpg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || advance;
   assign req_stall = !in_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         item_ff.kind       <= req_kind;
         item_ff.now_ms     <= req_now_ms;
         item_ff.new_status <= status_type'(req_new_status);
      end
   end

   slpg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_led_lit      = result_ff.led_lit;
   assign rsp_shown_status = result_ff.shown_status;

`ifndef SYNTH
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item did not reach the result register");

   a_set_shown: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.kind == KIND_SET) |=> rsp_shown_status == $past(item_ff.new_status))
      else $error("status change not shown");

   a_ok_lit: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.kind == KIND_TICK && u_core.mode_ff == STATUS_GOOD) |=> rsp_led_lit)
      else $error("LED not lit on tick in status OK");

   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while both registers are full and stalled");
`endif

endmodule

// ===== sim/tb_status_led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// tb_status_led_pattern_generator
// Self-checking testbench for the status LED pattern generator.
// ----------------------------------------------------------------------------
// Every accepted item updates a local model of the LED pattern state. The
// model queues the LED drive and status that the block should return. Each
// rsp_ transfer is checked against the oldest queued entry.
// The run has four parts. A directed part covers the default timings,
// status changes and time wrap-around. It is followed by timing extremes and
// random sessions under several timing settings. A last part holds the
// output back for a long stretch while items keep arriving.
// The sender works in bursts, and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_generator
   import slpg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 150;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [TIME_W-1:0]      req_now_ms;
   logic [1:0]             req_new_status;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_led_lit;
   logic [1:0]             rsp_shown_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DUR_W-1:0]       csr_data;

   cfg_type            timing_cfg;
   status_type         shown_mode;
   logic               led_now;
   logic [TIME_W-1:0]  last_ms;
   logic               pattern_on;
   logic [PHASE_W-1:0] phase_now;
   result_type         expected_leds[$];

   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  ticks_sent      = 0;
   int  sets_sent       = 0;
   int  timing_settings = 0;
   int  stall_style     = 0;
   int  hold_left       = 0;
   bit  hold_request    = 1'b0;

   status_led_pattern_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_now_ms       (req_now_ms),
      .req_new_status   (req_new_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_lit      (rsp_led_lit),
      .rsp_shown_status (rsp_shown_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void advance_pattern(input logic kind, input logic [TIME_W-1:0] now,
                                           input status_type ns);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] limit;
      result_type        want;
      elapsed = now - last_ms;
      if (kind == KIND_SET) begin
         if (ns != shown_mode) begin
            shown_mode = ns;
            phase_now  = PHASE_FIRST;
            pattern_on = 1'b0;
         end
      end else begin
         case (shown_mode)
            STATUS_GOOD: begin
               led_now = 1'b1;
            end
            STATUS_DOOR, STATUS_WARM: begin
               limit = (shown_mode == STATUS_DOOR) ? TIME_W'(timing_cfg.slow_half_ms)
                                                   : TIME_W'(timing_cfg.fast_half_ms);
               if (!pattern_on) begin
                  pattern_on = 1'b1;
                  last_ms    = now;
                  led_now    = 1'b1;
               end else if (elapsed >= limit) begin
                  led_now = ~led_now;
                  last_ms = now;
               end
            end
            default: begin
               limit = (phase_now >= PHASE_PAUSE) ? TIME_W'(timing_cfg.pause_ms)
                                                  : TIME_W'(timing_cfg.flash_ms);
               if (!pattern_on) begin
                  pattern_on = 1'b1;
                  last_ms    = now;
                  led_now    = 1'b1;
                  phase_now  = PHASE_FIRST;
               end else if (elapsed >= limit) begin
                  phase_now = (phase_now >= PHASE_PAUSE) ? PHASE_FIRST : phase_now + 3'd1;
                  last_ms   = now;
                  led_now   = ~phase_now[0];
               end
            end
         endcase
      end
      want.led_lit      = led_now;
      want.shown_status = shown_mode;
      expected_leds.push_back(want);
   endfunction

   function automatic void note_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
      end
   endfunction

   // Both channels are sampled on the falling edge ahead of the rising edge that
   // completes the transfer, so the values seen are the ones the block takes.
   always @(negedge clock) begin : monitor_blk
      result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_pattern(req_kind, req_now_ms, status_type'(req_new_status));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_leds.size() == 0) begin
               note_mismatch("unexpected transfer", 0, 1);
            end else begin
               want = expected_leds.pop_front();
               results_checked++;
               if (rsp_led_lit !== want.led_lit) begin
                  note_mismatch("led_lit", want.led_lit, rsp_led_lit);
               end
               if (rsp_shown_status !== want.shown_status) begin
                  note_mismatch("shown_status", want.shown_status, rsp_shown_status);
               end
            end
         end
      end
   end

   initial begin
      int stall_count;
      stall_count = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         stall_count++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               3:       rsp_stall <= ((stall_count % 7) >= 4);
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   task automatic send_item(input logic kind, input logic [TIME_W-1:0] now,
                            input status_type ns);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_now_ms     <= now;
      req_new_status <= ns;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      if (kind == KIND_SET) begin
         sets_sent++;
      end else begin
         ticks_sent++;
      end
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now);
      send_item(KIND_TICK, now, status_type'($urandom_range(0, 3)));
   endtask

   task automatic send_set(input status_type ns);
      send_item(KIND_SET, $urandom, ns);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_timing(input reg_index_type idx, input logic [DUR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      case (idx)
         REG_SLOW_HALF: timing_cfg.slow_half_ms = value;
         REG_FAST_HALF: timing_cfg.fast_half_ms = value;
         REG_FLASH:     timing_cfg.flash_ms     = value;
         default:       timing_cfg.pause_ms     = value;
      endcase
   endtask

   task automatic set_timings(input logic [DUR_W-1:0] slow, input logic [DUR_W-1:0] fast,
                              input logic [DUR_W-1:0] flash, input logic [DUR_W-1:0] pause);
      settle();
      write_timing(REG_SLOW_HALF, slow);
      write_timing(REG_FAST_HALF, fast);
      write_timing(REG_FLASH, flash);
      write_timing(REG_PAUSE, pause);
      csr_valid <= 1'b0;
      timing_settings++;
   endtask

   task automatic random_session(input int count, input int max_gap);
      int                burst_left;
      int                roll;
      logic [TIME_W-1:0] wall_ms;
      logic [TIME_W-1:0] hint;
      logic [TIME_W-1:0] step_ms;
      status_type        cur;
      burst_left = 0;
      cur        = shown_mode;
      wall_ms    = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 200000);
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               pause_sender($urandom_range(0, max_gap * 4));
            end else begin
               pause_sender($urandom_range(0, max_gap));
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            cur = status_type'($urandom_range(0, 3));
            send_set(cur);
         end else if (roll < 16) begin
            send_tick($urandom);
         end else begin
            case (cur)
               STATUS_DOOR: hint = TIME_W'(timing_cfg.slow_half_ms);
               STATUS_WARM: hint = TIME_W'(timing_cfg.fast_half_ms);
               default:     hint = ($urandom_range(0, 5) == 0) ? TIME_W'(timing_cfg.pause_ms)
                                                               : TIME_W'(timing_cfg.flash_ms);
            endcase
            if (roll < 40) begin
               step_ms = ($urandom_range(0, 1) || hint == 0) ? hint : hint - 1;
            end else begin
               step_ms = $urandom_range(0, 2 * hint + 2);
            end
            wall_ms = wall_ms + step_ms;
            send_tick(wall_ms);
         end
      end
   endtask

   task automatic test_default_patterns();
      stall_style = 1;
      send_tick(32'd0);
      send_tick(32'hFFFF_FFFF);
      send_set(STATUS_GOOD);
      send_set(STATUS_DOOR);
      send_tick(32'd100);
      send_tick(32'd1099);
      send_tick(32'd1100);
      send_tick(32'd50);
      pause_sender(3);
      send_set(STATUS_WARM);
      send_tick(32'hFFFF_FF00);
      send_tick(32'h0000_0010);
      send_set(STATUS_FAULT);
      send_tick(32'd0);
      send_tick(32'd149);
      send_tick(32'd150);
      send_tick(32'd300);
      pause_sender(2);
      send_tick(32'd450);
      send_tick(32'd600);
      send_tick(32'd750);
      send_tick(32'd1749);
      send_tick(32'd1750);
      send_tick(32'd1900);
      send_set(STATUS_WARM);
      send_set(STATUS_GOOD);
      send_tick(32'd7);
   endtask

   task automatic test_timing_extremes();
      stall_style = 3;
      set_timings(16'd0, 16'd0, 16'd0, 16'd0);
      random_session(70, 3);
      stall_style = 2;
      set_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_session(70, 3);
   endtask

   task automatic test_random_patterns();
      for (int s = 0; s < 5; s++) begin
         stall_style = $urandom_range(0, 3);
         case (s)
            0:       set_timings(SLOW_HALF_RESET, FAST_HALF_RESET, FLASH_RESET, PAUSE_RESET);
            1:       set_timings(DUR_W'($urandom_range(0, 40)), DUR_W'($urandom_range(0, 40)),
                                 DUR_W'($urandom_range(0, 40)), DUR_W'($urandom_range(0, 40)));
            2:       set_timings(DUR_W'($urandom_range(0, 65535)),
                                 DUR_W'($urandom_range(0, 65535)),
                                 DUR_W'($urandom_range(0, 65535)),
                                 DUR_W'($urandom_range(0, 65535)));
            3:       set_timings(DUR_W'($urandom_range(0, 3)), DUR_W'($urandom_range(0, 3)),
                                 DUR_W'($urandom_range(0, 3)), DUR_W'($urandom_range(0, 3)));
            default: set_timings(DUR_W'($urandom_range(500, 3000)),
                                 DUR_W'($urandom_range(50, 400)),
                                 DUR_W'($urandom_range(50, 300)),
                                 DUR_W'($urandom_range(500, 3000)));
         endcase
         random_session(170, (s == 0) ? 0 : 5);
      end
   endtask

   task automatic test_output_hold_off();
      settle();
      stall_style  = 0;
      hold_request = 1'b1;
      random_session(60, 0);
   endtask

   initial begin
      timing_cfg = '{slow_half_ms: SLOW_HALF_RESET, fast_half_ms: FAST_HALF_RESET,
                     flash_ms: FLASH_RESET, pause_ms: PAUSE_RESET};
      shown_mode     = STATUS_GOOD;
      led_now        = 1'b1;
      last_ms        = '0;
      pattern_on     = 1'b0;
      phase_now      = PHASE_FIRST;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_TICK;
      req_now_ms     <= '0;
      req_new_status <= STATUS_GOOD;
      csr_valid      <= 1'b0;
      csr_index      <= REG_SLOW_HALF;
      csr_data       <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_patterns();
      test_timing_extremes();
      test_random_patterns();
      test_output_hold_off();
      settle();

      $display("Covered %0d ticks and %0d status changes under %0d timing settings,",
               ticks_sent, sets_sent, timing_settings + 1);
      $display("with bursty input, stalled output and a long hold-off; %0d results compared.",
               results_checked);
      if (mismatch_count == 0 && expected_leds.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/slpg_pkg.sv
src/slpg_csr.sv
src/slpg_core.sv
src/status_led_pattern_generator.sv
sim/tb_status_led_pattern_generator.sv
